/* design/assert_macros.svh */
// Assertion macros used by the checker file of the frame store block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MPFB_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MPFB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/mpfb_pkg.sv */
// Shared types and command codes of the monochrome page frame store.
// No dependencies.
package mpfb_pkg;

	localparam logic [1:0] CMD_PLOT = 2'd0;
	localparam logic [1:0] CMD_FILL = 2'd1;
	localparam logic [1:0] CMD_PLUS = 2'd2;
	localparam logic [1:0] CMD_READ = 2'd3;

	// One access to the frame store; the address travels beside it.
	typedef struct packed {
		logic       wr;       // read-modify-write the addressed byte
		logic       rd;       // return the addressed byte as a result
		logic       rd_zero;  // out-of-range read: return zero
		logic       on;       // set (1) or clear (0) the masked bits
		logic [7:0] mask;
	} pix_op_t;

endpackage

/* design/mpfb_seq.sv */
// Command sequencer: clearing pass, point, fill and plus stepping, read issue.
// Depends on mpfb_pkg.
module mpfb_seq #(
	parameter int SCREEN_WIDTH = 128,
	parameter int PAGE_COUNT = 8,
	localparam int DEPTH = SCREEN_WIDTH * PAGE_COUNT,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          command,
	input  logic [7:0]          x,
	input  logic [7:0]          y,
	input  logic [7:0]          x_end,
	input  logic [7:0]          y_end,
	input  logic                pixel_on,
	input  logic [2:0]          page,
	input  logic [6:0]          column,
	input  logic                read_block,
	output mpfb_pkg::pix_op_t   op,
	output logic [AW-1:0]       op_addr
);
	import mpfb_pkg::*;

	localparam int ROWS = PAGE_COUNT * 8;
	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_FILL  = 2'd2;
	localparam logic [1:0] ST_PLUS  = 2'd3;

	logic [1:0]    state_q;
	logic [AW-1:0] clr_addr_q;
	logic [2:0]    step_q;
	logic [7:0]    col_q, row_q, y0_q, xe_q, ye_q;
	logic          on_q;

	logic          accept;
	logic [7:0]    xe_c, ye_c;
	logic          fill_empty;
	logic [8:0]    plus_x, plus_y;
	logic [8:0]    px9, py9;
	logic          pen, pon;
	logic [AW+7:0] rd_full;
	logic          rd_zero;

	function automatic logic [AW-1:0] pix_addr(input logic [8:0] px, input logic [8:0] py);
		logic [AW+8:0] t;
		t = (AW+9)'(px) * (AW+9)'(PAGE_COUNT) + (AW+9)'(PAGE_COUNT - 1)
			- (AW+9)'(py[8:3]);
		return t[AW-1:0];
	endfunction

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE) || ((command == CMD_READ) && read_block);

	// Clip fill ends to the screen edge before the empty test.
	assign xe_c = ({1'b0, x_end} > 9'(SCREEN_WIDTH - 1)) ? 8'(SCREEN_WIDTH - 1) : x_end;
	assign ye_c = ({1'b0, y_end} > 9'(ROWS - 1)) ? 8'(ROWS - 1) : y_end;
	assign fill_empty = (x > xe_c) || (y > ye_c);

	assign rd_full = (AW+8)'(column) * (AW+8)'(PAGE_COUNT) + (AW+8)'(page);
	assign rd_zero = ({2'b00, column} >= 9'(SCREEN_WIDTH))
		|| ({3'b000, page} >= 6'(PAGE_COUNT));

	// Plus-sign neighbors without 8-bit wrap; -1 becomes 511 and falls off screen.
	always_comb begin
		plus_x = {1'b0, col_q};
		plus_y = {1'b0, row_q};
		unique case (step_q)
			3'd0: plus_y = {1'b0, row_q} - 9'd1;
			3'd1: plus_y = {1'b0, row_q};
			3'd2: plus_y = {1'b0, row_q} + 9'd1;
			3'd3: plus_x = {1'b0, col_q} - 9'd1;
			default: plus_x = {1'b0, col_q} + 9'd1;
		endcase
	end

	always_comb begin
		op      = '0;
		op_addr = '0;
		pen     = 1'b0;
		pon     = 1'b0;
		px9     = {1'b0, x};
		py9     = {1'b0, y};
		unique case (state_q)
			ST_CLEAR: begin
				op.wr   = 1'b1;
				op.mask = 8'hFF;
				op_addr = clr_addr_q;
			end
			ST_IDLE: begin
				if (accept && command == CMD_PLOT) begin
					pen = 1'b1;
					pon = pixel_on;
				end
				if (accept && command == CMD_READ) begin
					op.rd      = 1'b1;
					op.rd_zero = rd_zero;
					op_addr    = rd_zero ? '0 : rd_full[AW-1:0];
				end
			end
			ST_FILL: begin
				pen = 1'b1;
				pon = on_q;
				px9 = {1'b0, col_q};
				py9 = {1'b0, row_q};
			end
			default: begin
				pen = 1'b1;
				pon = 1'b1;
				px9 = plus_x;
				py9 = plus_y;
			end
		endcase
		// Drop points that land off screen.
		if (pen && px9 < 9'(SCREEN_WIDTH) && py9 < 9'(ROWS)) begin
			op.wr   = 1'b1;
			op.on   = pon;
			op.mask = 8'h80 >> py9[2:0];
			op_addr = pix_addr(px9, py9);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			step_q     <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == AW'(DEPTH - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					step_q <= '0;
					if (accept && command == CMD_FILL && !fill_empty)
						state_q <= ST_FILL;
					if (accept && command == CMD_PLUS)
						state_q <= ST_PLUS;
				end
				ST_FILL: begin
					if (row_q == ye_q && col_q == xe_q)
						state_q <= ST_IDLE;
				end
				default: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd4)
						state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Fill and plus operands; column outer, row inner.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			col_q <= x;
			row_q <= y;
			y0_q  <= y;
			xe_q  <= xe_c;
			ye_q  <= ye_c;
			on_q  <= pixel_on;
		end else if (state_q == ST_FILL) begin
			if (row_q == ye_q) begin
				row_q <= y0_q;
				col_q <= col_q + 8'd1;
			end else begin
				row_q <= row_q + 8'd1;
			end
		end
	end

endmodule

/* design/mpfb_store.sv */
// Frame store memory with a one-stage read-modify-write pipe and write forwarding.
// Depends on mpfb_pkg.
module mpfb_store #(
	parameter int SCREEN_WIDTH = 128,
	parameter int PAGE_COUNT = 8,
	localparam int DEPTH = SCREEN_WIDTH * PAGE_COUNT,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mpfb_pkg::pix_op_t op,
	input  logic [AW-1:0]     op_addr,
	output logic              res_valid,
	output logic [7:0]        res_data
);
	import mpfb_pkg::*;

	logic [7:0]    mem [DEPTH];
	logic [7:0]    rdata_q;
	pix_op_t       op_s1;
	logic [AW-1:0] addr_s1;
	logic          fwd_s1;
	logic [7:0]    fwd_data_s1;
	logic [7:0]    cur;
	logic [7:0]    wdata;

	// The byte written this cycle is newer than what the memory returns next.
	assign cur   = fwd_s1 ? fwd_data_s1 : rdata_q;
	assign wdata = op_s1.on ? (cur | op_s1.mask) : (cur & ~op_s1.mask);

	assign res_valid = op_s1.rd;
	assign res_data  = op_s1.rd_zero ? 8'h00 : cur;

	always_ff @(posedge clk) begin
		rdata_q <= mem[op_addr];
		if (op_s1.wr)
			mem[addr_s1] <= wdata;
		addr_s1     <= op_addr;
		fwd_data_s1 <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1  <= '0;
			fwd_s1 <= 1'b0;
		end else begin
			op_s1  <= op;
			fwd_s1 <= op_s1.wr && (addr_s1 == op_addr);
		end
	end

endmodule

/* design/mono_page_framebuffer_draw.sv */
// Top level of the monochrome page frame store: sequencer, store, result register.
// Depends on mpfb_pkg, mpfb_seq and mpfb_store.
//
// A SCREEN_WIDTH x (PAGE_COUNT*8) one-bit frame store, kept as PAGE_COUNT pages of
// column bytes; pixel (x,y) is bit 7-y%8 of page PAGE_COUNT-1-y/8. After reset the
// block runs a clearing pass over all SCREEN_WIDTH*PAGE_COUNT bytes (1024 by
// default) with in_stall high. Then a point or a read is issued as it is accepted;
// a plus sign is accepted, then steps through its five pixels; a fill is accepted,
// then steps through every pixel of the rectangle after clipping to the screen (an
// empty fill is only accepted). The memory sets this pace: every pixel is one
// read-modify-write through its read and write ports, and back-to-back accesses to
// one byte are forwarded. Only reads return an item; a read is held off while an
// earlier read is in flight or a result waits stalled, other commands are not.
module mono_page_framebuffer_draw #(
	parameter int SCREEN_WIDTH = 128,
	parameter int PAGE_COUNT = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] command,
	input  logic [7:0] x,
	input  logic [7:0] y,
	input  logic [7:0] x_end,
	input  logic [7:0] y_end,
	input  logic       pixel_on,
	input  logic [2:0] page,
	input  logic [6:0] column,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] page_byte
);
	import mpfb_pkg::*;

	localparam int AW = $clog2(SCREEN_WIDTH * PAGE_COUNT);

	pix_op_t       op;
	logic [AW-1:0] op_addr;
	logic          res_valid;
	logic [7:0]    res_data;
	logic          read_block;
	logic          out_valid_q;
	logic [7:0]    page_byte_q;

	// Hold off a new read while a result is still in the pipe or stuck at the port.
	assign read_block = res_valid || (out_valid_q && out_stall);

	mpfb_seq #(
		.SCREEN_WIDTH(SCREEN_WIDTH),
		.PAGE_COUNT(PAGE_COUNT)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.x(x),
		.y(y),
		.x_end(x_end),
		.y_end(y_end),
		.pixel_on(pixel_on),
		.page(page),
		.column(column),
		.read_block(read_block),
		.op(op),
		.op_addr(op_addr)
	);

	mpfb_store #(
		.SCREEN_WIDTH(SCREEN_WIDTH),
		.PAGE_COUNT(PAGE_COUNT)
	) u_store (
		.clk(clk),
		.arst_n(arst_n),
		.op(op),
		.op_addr(op_addr),
		.res_valid(res_valid),
		.res_data(res_data)
	);

	// Result register: load on a finished read, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid)
			page_byte_q <= res_data;
	end

	assign out_valid = out_valid_q;
	assign page_byte = page_byte_q;

endmodule

/* design/mpfb_checker.sv */
// Port-level checker for mono_page_framebuffer_draw, bound to the top level.
// Depends on mpfb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mpfb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [1:0] command,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] page_byte
);
	import mpfb_pkg::*;

	logic rd_acc;
	assign rd_acc = in_valid && !in_stall && (command == CMD_READ);

	`MPFB_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(page_byte), "stalled result changed")
	`MPFB_ASSERT(a_read_latency, clk, arst_n, rd_acc, ##2 out_valid, "read result not shown two cycles after accept")
	`MPFB_ASSERT(a_no_phantom, clk, arst_n, $rose(out_valid), $past(rd_acc, 2), "result without a read")
	`MPFB_ASSERT(a_read_slot, clk, arst_n, rd_acc, !(out_valid && out_stall), "read accepted while result slot is blocked")

endmodule

bind mono_page_framebuffer_draw mpfb_checker u_chk (.*);

/* verif/fb_draw_checker.sv */
// Scoreboard for the monochrome page frame store: keeps a shadow copy of the
// pixels, predicts every page byte read back and compares it with the block.
// Depends on mpfb_pkg for the command codes.
module fb_draw_checker #(
	parameter int SCREEN_WIDTH = 128,
	parameter int PAGE_COUNT = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [1:0] command,
	input  logic [7:0] x,
	input  logic [7:0] y,
	input  logic [7:0] x_end,
	input  logic [7:0] y_end,
	input  logic       pixel_on,
	input  logic [2:0] page,
	input  logic [6:0] column,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [7:0] page_byte,
	output int         fail_count,
	output int         pending,
	output int         bytes_checked
);
	import mpfb_pkg::*;

	localparam int SCREEN_ROWS = PAGE_COUNT * 8;
	localparam int STORE_BYTES = SCREEN_WIDTH * PAGE_COUNT;

	logic [7:0] shadow_frame [STORE_BYTES];
	logic [7:0] bytes_due [$];
	logic [7:0] want_byte;

	task automatic flag_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		$display("[%0t] MISMATCH %s: page_byte got %02h want %02h", $realtime, what,
			got, want);
		fail_count = fail_count + 1;
	endtask

	// Off-screen pixels, including plus arms at -1 or past the edge, are dropped.
	function automatic void paint_pixel(input int px, input int py, input logic on);
		int idx;
		logic [7:0] bit_sel;
		if (px < 0 || py < 0 || px >= SCREEN_WIDTH || py >= SCREEN_ROWS)
			return;
		idx = px * PAGE_COUNT + (PAGE_COUNT - 1 - py / 8);
		bit_sel = 8'h80 >> (py % 8);
		if (on)
			shadow_frame[idx] = shadow_frame[idx] | bit_sel;
		else
			shadow_frame[idx] = shadow_frame[idx] & ~bit_sel;
	endfunction

	function automatic void fill_rect(input int x0, input int y0, input int x1,
			input int y1, input logic on);
		if (x0 > x1 || y0 > y1)
			return;
		if (x1 > SCREEN_WIDTH - 1)
			x1 = SCREEN_WIDTH - 1;
		if (y1 > SCREEN_ROWS - 1)
			y1 = SCREEN_ROWS - 1;
		for (int cx = x0; cx <= x1; cx++)
			for (int cy = y0; cy <= y1; cy++)
				paint_pixel(cx, cy, on);
	endfunction

	function automatic logic [7:0] stored_byte(input int pg, input int col);
		if (pg >= PAGE_COUNT || col >= SCREEN_WIDTH)
			return 8'h00;
		return shadow_frame[col * PAGE_COUNT + pg];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STORE_BYTES; i++)
				shadow_frame[i] = 8'h00;
			bytes_due.delete();
			fail_count = 0;
			pending = 0;
			bytes_checked = 0;
		end else begin
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				if (bytes_due.size() == 0) begin
					flag_mismatch("result with nothing due", page_byte, 8'h00);
				end else begin
					want_byte = bytes_due.pop_front();
					bytes_checked = bytes_checked + 1;
					if (page_byte !== want_byte)
						flag_mismatch("read back", page_byte, want_byte);
				end
			end
			if (in_valid && !in_stall) begin
				case (command)
					CMD_PLOT: paint_pixel(x, y, pixel_on);
					CMD_FILL: fill_rect(x, y, x_end, y_end, pixel_on);
					CMD_PLUS: begin
						paint_pixel(x, y - 1, 1'b1);
						paint_pixel(x, y, 1'b1);
						paint_pixel(x, y + 1, 1'b1);
						paint_pixel(x - 1, y, 1'b1);
						paint_pixel(x + 1, y, 1'b1);
					end
					CMD_READ: bytes_due.push_back(stored_byte(page, column));
					default: ;
				endcase
			end
			pending = bytes_due.size();
		end
	end

endmodule

/* verif/tb.sv */
// Top of the frame store testbench: clock, reset, drawing stimulus, result
// stall pattern and the verdict. Depends on mpfb_pkg, fb_draw_checker and the block.
module tb;
	import mpfb_pkg::*;

	localparam int SCREEN_WIDTH = 128;
	localparam int PAGE_COUNT = 8;
	localparam int RANDOM_ITEMS = 630;
	// Slowest sane run: clearing pass, a few full-screen fills of 8192 pixels each,
	// long gaps and stalls on top. Several times over that.
	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int DRAIN_CYCLES = 64;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [1:0] command = CMD_PLOT;
	logic [7:0] x = 8'h00;
	logic [7:0] y = 8'h00;
	logic [7:0] x_end = 8'h00;
	logic [7:0] y_end = 8'h00;
	logic       pixel_on = 1'b0;
	logic [2:0] page = 3'd0;
	logic [6:0] column = 7'd0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] page_byte;

	int fail_count;
	int pending;
	int bytes_checked;

	// Items accepted per command, for the closing summary.
	int items_by_cmd [4];
	// Recently drawn spot; targeted reads look there so writes get read back.
	int hot_x;
	int hot_y;
	// While set, the sender offers items back to back.
	bit steady_run;

	mono_page_framebuffer_draw #(
		.SCREEN_WIDTH(SCREEN_WIDTH),
		.PAGE_COUNT(PAGE_COUNT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.x(x),
		.y(y),
		.x_end(x_end),
		.y_end(y_end),
		.pixel_on(pixel_on),
		.page(page),
		.column(column),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.page_byte(page_byte)
	);

	fb_draw_checker #(
		.SCREEN_WIDTH(SCREEN_WIDTH),
		.PAGE_COUNT(PAGE_COUNT)
	) chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.x(x),
		.y(y),
		.x_end(x_end),
		.y_end(y_end),
		.pixel_on(pixel_on),
		.page(page),
		.column(column),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.page_byte(page_byte),
		.fail_count(fail_count),
		.pending(pending),
		.bytes_checked(bytes_checked)
	);

	initial begin : clock_gen
		forever #5 clk = ~clk;
	end

	// Present one item and hold it until the block takes it. Called at a rising
	// edge, so valid stays high across back-to-back items with a single update.
	task automatic send_item(input logic [1:0] cmd, input logic [7:0] px,
			input logic [7:0] py, input logic [7:0] ex, input logic [7:0] ey,
			input logic on, input logic [2:0] pg, input logic [6:0] col);
		in_valid <= 1'b1;
		command <= cmd;
		x <= px;
		y <= py;
		x_end <= ex;
		y_end <= ey;
		pixel_on <= on;
		page <= pg;
		column <= col;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_by_cmd[cmd] = items_by_cmd[cmd] + 1;
		if (cmd != CMD_READ && px < SCREEN_WIDTH && py < PAGE_COUNT * 8) begin
			hot_x = px;
			hot_y = py;
		end
	endtask

	// Drop valid for a random stretch: mostly none or short, now and then long.
	task automatic sender_gap();
		int pick;
		int len;
		pick = $urandom_range(0, 99);
		if (steady_run || pick < 55)
			len = 0;
		else if (pick < 90)
			len = $urandom_range(1, 3);
		else
			len = $urandom_range(8, 40);
		if (len > 0) begin
			in_valid <= 1'b0;
			repeat (len) @(posedge clk);
		end
	endtask

	function automatic logic [7:0] clip_add(input int base, input int delta);
		return (base + delta > 255) ? 8'd255 : 8'(base + delta);
	endfunction

	task automatic random_item();
		int pick;
		int mode;
		logic [7:0] px;
		logic [7:0] py;
		logic [7:0] ex;
		logic [7:0] ey;
		logic [2:0] pg;
		logic [6:0] col;
		pick = $urandom_range(0, 99);
		px = 8'($urandom_range(0, 135));
		py = 8'($urandom_range(0, 70));
		ex = 8'($urandom);
		ey = 8'($urandom);
		pg = 3'($urandom);
		col = 7'($urandom);
		if (pick < 26) begin
			send_item(CMD_PLOT, px, py, ex, ey, 1'($urandom), pg, col);
		end else if (pick < 38) begin
			// Mostly small rectangles; some run to the far edge, a few are arbitrary.
			mode = $urandom_range(0, 9);
			if (mode < 7) begin
				ex = clip_add(px, $urandom_range(0, 9));
				ey = clip_add(py, $urandom_range(0, 7));
			end else if (mode < 9) begin
				px = 8'($urandom_range(96, 255));
				py = 8'($urandom_range(40, 255));
				ex = 8'd255;
				ey = 8'd255;
			end
			send_item(CMD_FILL, px, py, ex, ey, 1'($urandom), pg, col);
		end else if (pick < 52) begin
			send_item(CMD_PLUS, px, py, ex, ey, 1'($urandom), pg, col);
		end else if (pick < 78) begin
			// Read near the spot drawn last.
			col = 7'(hot_x + $urandom_range(0, 2) - 1);
			pg = 3'(PAGE_COUNT - 1 - hot_y / 8);
			send_item(CMD_READ, px, py, ex, ey, 1'($urandom), pg, col);
		end else if (pick < 92) begin
			send_item(CMD_READ, px, py, ex, ey, 1'($urandom), pg, col);
		end else begin
			// Noise over the full width of every field.
			send_item(2'($urandom), 8'($urandom), 8'($urandom), ex, ey, 1'($urandom),
				pg, col);
		end
	endtask

	// Result side: stretches free of stall, random stall, short and long holds,
	// and one long hold-off so reads back up and the block stalls its input.
	initial begin : result_stall
		int seg_len;
		int mode;
		bit long_hold_done;
		long_hold_done = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			mode = $urandom_range(0, 9);
			seg_len = $urandom_range(1, 40);
			if (!long_hold_done && bytes_checked >= 20) begin
				long_hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (500) @(posedge clk);
			end else if (mode < 4) begin
				out_stall <= 1'b0;
				repeat (seg_len) @(posedge clk);
			end else if (mode < 8) begin
				repeat (seg_len) begin
					out_stall <= ($urandom_range(0, 9) < 3);
					@(posedge clk);
				end
			end else if (mode == 8) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end else begin
				out_stall <= 1'b1;
				repeat ($urandom_range(20, 80)) @(posedge clk);
			end
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles = cycles + 1;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles, %0d reads outstanding", cycles, pending);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [7:0] any_a;
		logic [7:0] any_b;
		hot_x = 0;
		hot_y = 0;
		steady_run = 1'b0;
		for (int i = 0; i < 4; i++)
			items_by_cmd[i] = 0;
		any_a = 8'($urandom);
		any_b = 8'($urandom);

		// Hold reset, then release on an edge; the clearing pass follows with
		// the input stalled, which send_item simply waits out.
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: corners, off-screen points, plus signs at the edges,
		// empty fills, fills clipped at the screen edge, full-screen set and clear.
		send_item(CMD_READ, any_a, any_b, any_a, any_b, 1'b0, 3'd0, 7'd0);
		send_item(CMD_PLOT, 8'd0, 8'd0, any_a, any_b, 1'b1, 3'd7, 7'd127);
		send_item(CMD_PLOT, 8'd127, 8'd63, any_a, any_b, 1'b1, 3'd0, 7'd0);
		send_item(CMD_PLOT, 8'd128, 8'd10, any_a, any_b, 1'b1, 3'd5, 7'd3);
		send_item(CMD_PLOT, 8'd255, 8'd255, any_a, any_b, 1'b1, 3'd2, 7'd64);
		send_item(CMD_PLOT, 8'd5, 8'd64, any_a, any_b, 1'b1, 3'd1, 7'd9);
		send_item(CMD_READ, any_a, any_b, any_a, any_b, 1'b1, 3'd7, 7'd0);
		send_item(CMD_READ, any_a, any_b, any_a, any_b, 1'b0, 3'd0, 7'd127);
		send_item(CMD_PLUS, 8'd0, 8'd0, any_a, any_b, 1'b0, 3'd0, 7'd0);
		send_item(CMD_PLUS, 8'd127, 8'd63, any_a, any_b, 1'b0, 3'd0, 7'd0);
		send_item(CMD_PLUS, 8'd255, 8'd255, any_a, any_b, 1'b1, 3'd0, 7'd0);
		send_item(CMD_READ, any_a, any_b, any_a, any_b, 1'b0, 3'd7, 7'd1);
		send_item(CMD_FILL, 8'd10, 8'd10, 8'd5, 8'd20, 1'b1, 3'd0, 7'd0);
		send_item(CMD_FILL, 8'd10, 8'd20, 8'd12, 8'd5, 1'b1, 3'd0, 7'd0);
		send_item(CMD_FILL, 8'd120, 8'd56, 8'd255, 8'd255, 1'b1, 3'd0, 7'd0);
		send_item(CMD_READ, any_a, any_b, any_a, any_b, 1'b0, 3'd0, 7'd124);
		send_item(CMD_FILL, 8'd0, 8'd0, 8'd255, 8'd255, 1'b1, 3'd0, 7'd0);
		send_item(CMD_READ, any_a, any_b, any_a, any_b, 1'b0, 3'd3, 7'd64);
		send_item(CMD_FILL, 8'd0, 8'd0, 8'd255, 8'd255, 1'b0, 3'd0, 7'd0);
		send_item(CMD_PLOT, 8'd64, 8'd32, any_a, any_b, 1'b1, 3'd0, 7'd0);
		send_item(CMD_READ, any_a, any_b, any_a, any_b, 1'b0, 3'd3, 7'd64);
		send_item(CMD_PLOT, 8'd64, 8'd32, any_a, any_b, 1'b0, 3'd0, 7'd0);
		send_item(CMD_READ, any_a, any_b, any_a, any_b, 1'b1, 3'd3, 7'd64);
		send_item(CMD_READ, any_a, any_b, any_a, any_b, 1'b1, 3'd7, 7'd127);

		// Random part, with back-to-back stretches every so often.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0)
				steady_run = ($urandom_range(0, 3) == 0);
			sender_gap();
			random_item();
		end
		in_valid <= 1'b0;
		// Let the scoreboard log the last accepted item before looking at its count.
		@(posedge clk);

		// Drain outstanding reads, then let any trailing drawing settle.
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d plots, %0d fills, %0d plus signs, %0d reads",
			items_by_cmd[CMD_PLOT], items_by_cmd[CMD_FILL], items_by_cmd[CMD_PLUS],
			items_by_cmd[CMD_READ]);
		$display("%0d page bytes compared, %0d mismatches", bytes_checked, fail_count);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

/* mono_page_framebuffer_draw.f */
+incdir+design
design/mpfb_pkg.sv
design/mpfb_seq.sv
design/mpfb_store.sv
design/mono_page_framebuffer_draw.sv
design/mpfb_checker.sv
verif/fb_draw_checker.sv
verif/tb.sv
